// ===== src/npc_res_pkg.sv =====
// Shared constants and stream widths for the RISC-V next-pc resolver.
// Used by riscv_next_pc_resolver_unit; no dependencies of its own.
`default_nettype none

package npc_res_pkg;

	// Request kinds carried on s_tuser
	localparam logic FUNC_WRITE   = 1'b0;
	localparam logic FUNC_RESOLVE = 1'b1;

	// Stream widths (packed fields rounded up to whole bytes)
	localparam int IN_TDATA_W  = 168;
	localparam int OUT_TDATA_W = 72;

	// Input tdata field positions
	localparam int IN_IDX_LO  = 0;
	localparam int IN_VAL_LO  = 5;
	localparam int IN_INSN_LO = 69;
	localparam int IN_PC_LO   = 101;
	localparam int IN_OK_BIT  = 165;

	// 32-bit major opcodes
	localparam logic [6:0] OPC_JAL    = 7'h6F;
	localparam logic [6:0] OPC_JALR   = 7'h67;
	localparam logic [6:0] OPC_BRANCH = 7'h63;

	// B-type funct3 codes
	localparam logic [2:0] F3_BEQ  = 3'd0;
	localparam logic [2:0] F3_BNE  = 3'd1;
	localparam logic [2:0] F3_BLT  = 3'd4;
	localparam logic [2:0] F3_BGE  = 3'd5;
	localparam logic [2:0] F3_BLTU = 3'd6;
	localparam logic [2:0] F3_BGEU = 3'd7;
	localparam logic [2:0] F3_JALR = 3'd0;

	// funct3 values of the branch opcode that name no branch
	localparam logic [2:0] F3_BR_RSVD_A = 3'd2;
	localparam logic [2:0] F3_BR_RSVD_B = 3'd3;

	// Compressed quadrants and funct3 codes
	localparam logic [1:0] CQ_1     = 2'b01;
	localparam logic [1:0] CQ_2     = 2'b10;
	localparam logic [1:0] CQ_NONE  = 2'b11;
	localparam logic [2:0] CF3_J    = 3'd5;
	localparam logic [2:0] CF3_BEQZ = 3'd6;
	localparam logic [2:0] CF3_BNEZ = 3'd7;
	localparam logic [2:0] CF3_JR   = 3'd4;

	// Instruction lengths
	localparam logic [2:0] LEN_C = 3'd2;
	localparam logic [2:0] LEN_W = 3'd4;

endpackage

`default_nettype wire

// ===== src/npc_res_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Standalone; used for the integer register file copies.
`default_nettype none

module npc_res_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== src/riscv_next_pc_resolver_unit.sv =====
// RISC-V next-pc resolver: register file plus next-pc decode for jumps and branches.
// Depends on npc_res_pkg and npc_res_ram.
//
// Usage:
//   s_* carries requests. s_tuser is the kind: 0 writes reg_value into register
//   reg_index (x0 writes are dropped, no result); 1 resolves the instruction in
//   insn_word at pc and yields one result on m_*.
//   A resolve request passes the register-file read stage, then the result
//   register, before its result shows on m_*.
//   Throughput: one request per cycle unless m_* stalls, writes and resolves
//   mixed freely; a write is visible to a resolve accepted in the very next cycle.
//   The register file is two RAM copies (one per source operand), each with one
//   write and one registered read port; 32 valid flops make unwritten registers
//   read as zero, so no clearing pass is needed.
//   Reset: all registers read as zero, both stages empty, s_tready high.
//   Stall: when m_tready is low the result register holds, the read stage fills,
//   and then s_tready drops until the result is taken.
`default_nettype none

module riscv_next_pc_resolver_unit #(
	parameter int XLEN = 64
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	// tdata: reg_index[4:0], reg_value[68:5], insn_word[100:69], pc[164:101],
	//        fetch_ok[165], zero pad [167:166]
	input  wire logic [npc_res_pkg::IN_TDATA_W-1:0] s_tdata,
	// tuser: func (0 write, 1 resolve)
	input  wire logic                               s_tuser,
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	// tdata: next_pc[63:0], inst_size[66:64], is_branch[67], zero pad [71:68]
	output logic [npc_res_pkg::OUT_TDATA_W-1:0]     m_tdata
);

	import npc_res_pkg::*;

	localparam int NREGS = 32;
	localparam int AW    = $clog2(NREGS);

	// Input field unpacking
	logic [AW-1:0]   in_idx;
	logic [XLEN-1:0] in_val;
	logic [31:0]     in_insn;
	logic [XLEN-1:0] in_pc;
	logic            in_ok;
	logic            accept;
	logic            wr_en;
	logic            rd_req;
	logic [AW-1:0]   rs_a_addr;
	logic [AW-1:0]   rs_b_addr;

	assign in_idx  = s_tdata[IN_IDX_LO +: AW];
	assign in_val  = XLEN'(s_tdata[IN_VAL_LO +: 64]);
	assign in_insn = s_tdata[IN_INSN_LO +: 32];
	assign in_pc   = XLEN'(s_tdata[IN_PC_LO +: 64]);
	assign in_ok   = s_tdata[IN_OK_BIT];

	assign accept = s_tvalid && s_tready;
	assign wr_en  = accept && (s_tuser == FUNC_WRITE) && (in_idx != '0);
	assign rd_req = accept && (s_tuser == FUNC_RESOLVE);

	// Source register selection from the raw word
	always_comb begin
		if (in_insn[1:0] == CQ_1) begin
			rs_a_addr = {2'b01, in_insn[9:7]};
		end else if (in_insn[1:0] != CQ_NONE) begin
			rs_a_addr = in_insn[11:7];
		end else begin
			rs_a_addr = in_insn[19:15];
		end
		rs_b_addr = in_insn[24:20];
	end

	// Register valid bits: an unwritten register (and x0) reads as zero
	logic [NREGS-1:0] reg_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reg_valid_q <= '0;
		end else if (wr_en) begin
			reg_valid_q[in_idx] <= 1'b1;
		end
	end

	// Register file copies, one per operand
	logic [XLEN-1:0] rd_a_s1;
	logic [XLEN-1:0] rd_b_s1;

	npc_res_ram #(.WIDTH(XLEN), .DEPTH(NREGS)) u_rf_a (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (in_idx),
		.wr_data (in_val),
		.rd_en   (rd_req),
		.rd_addr (rs_a_addr),
		.rd_data (rd_a_s1)
	);

	npc_res_ram #(.WIDTH(XLEN), .DEPTH(NREGS)) u_rf_b (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (in_idx),
		.wr_data (in_val),
		.rd_en   (rd_req),
		.rd_addr (rs_b_addr),
		.rd_data (rd_b_s1)
	);

	// Read stage
	logic            valid_s1;
	logic [31:0]     insn_s1;
	logic [XLEN-1:0] pc_s1;
	logic            ok_s1;
	logic            a_ok_s1;
	logic            b_ok_s1;
	logic            out_valid_q;
	logic            advance;

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= rd_req;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_req) begin
			insn_s1 <= in_insn;
			pc_s1   <= in_pc;
			ok_s1   <= in_ok;
			a_ok_s1 <= reg_valid_q[rs_a_addr];
			b_ok_s1 <= reg_valid_q[rs_b_addr];
		end
	end

	// Operands and decode
	logic [XLEN-1:0] op_a;
	logic [XLEN-1:0] op_b;
	logic [15:0]     c;
	logic [2:0]      cf3;
	logic [2:0]      f3;
	logic [11:0]     imm_cj;
	logic [8:0]      imm_cb;
	logic [20:0]     imm_jal;
	logic [11:0]     imm_jalr;
	logic [12:0]     imm_b;
	logic            br_eq;
	logic            br_lt;
	logic            br_ltu;
	logic            taken;
	logic            use_off;
	logic [XLEN-1:0] off;
	logic [XLEN-1:0] pc_off;
	logic [XLEN-1:0] pc_fall;
	logic [XLEN-1:0] jalr_sum;
	logic [XLEN-1:0] npc_base;
	logic [XLEN-1:0] next_pc;
	logic [2:0]      len;
	logic            is_br;

	assign op_a = a_ok_s1 ? rd_a_s1 : '0;
	assign op_b = b_ok_s1 ? rd_b_s1 : '0;
	assign c    = insn_s1[15:0];
	assign cf3  = c[15:13];
	assign f3   = insn_s1[14:12];

	assign imm_cj   = {c[12], c[8], c[10:9], c[6], c[7], c[2], c[11], c[5:3], 1'b0};
	assign imm_cb   = {c[12], c[6:5], c[2], c[11:10], c[4:3], 1'b0};
	assign imm_jal  = {insn_s1[31], insn_s1[19:12], insn_s1[20], insn_s1[30:21], 1'b0};
	assign imm_jalr = insn_s1[31:20];
	assign imm_b    = {insn_s1[31], insn_s1[7], insn_s1[30:25], insn_s1[11:8], 1'b0};

	// Length: a failed fetch counts as a full word
	assign len = (ok_s1 && c[1:0] != CQ_NONE) ? LEN_C : LEN_W;

	// Comparators
	assign br_eq  = (op_a == op_b);
	assign br_lt  = ($signed(op_a) < $signed(op_b));
	assign br_ltu = (op_a < op_b);

	// Adders
	assign pc_off   = pc_s1 + off;
	assign pc_fall  = pc_s1 + XLEN'(len);
	assign jalr_sum = op_a + XLEN'($signed(imm_jalr));

	// Next-pc selection
	always_comb begin
		is_br    = 1'b0;
		taken    = 1'b0;
		use_off  = 1'b0;
		off      = '0;
		npc_base = pc_fall;
		if (!ok_s1) begin
			npc_base = pc_fall;
		end else if (c[1:0] != CQ_NONE) begin
			if (c[1:0] == CQ_1 && cf3 == CF3_J) begin
				off     = XLEN'($signed(imm_cj));
				use_off = 1'b1;
			end else if (c[1:0] == CQ_1 && (cf3 == CF3_BEQZ || cf3 == CF3_BNEZ)) begin
				off     = XLEN'($signed(imm_cb));
				is_br   = 1'b1;
				taken   = (cf3 == CF3_BEQZ) ? (op_a == '0) : (op_a != '0);
				use_off = taken;
			end else if (c[1:0] == CQ_2 && cf3 == CF3_JR && c[6:2] == '0 && c[11:7] != '0) begin
				npc_base = {op_a[XLEN-1:1], 1'b0};
			end
		end else begin
			if (insn_s1[6:0] == OPC_JAL) begin
				off     = XLEN'($signed(imm_jal));
				use_off = 1'b1;
			end else if (insn_s1[6:0] == OPC_JALR && f3 == F3_JALR) begin
				npc_base = {jalr_sum[XLEN-1:1], 1'b0};
			end else if (insn_s1[6:0] == OPC_BRANCH && f3 != F3_BR_RSVD_A &&
					f3 != F3_BR_RSVD_B) begin
				off   = XLEN'($signed(imm_b));
				is_br = 1'b1;
				case (f3)
					F3_BEQ:  taken = br_eq;
					F3_BNE:  taken = !br_eq;
					F3_BLT:  taken = br_lt;
					F3_BGE:  taken = !br_lt;
					F3_BLTU: taken = br_ltu;
					F3_BGEU: taken = !br_ltu;
					default: taken = 1'b0;
				endcase
				use_off = taken;
			end
		end
	end

	// pc-relative targets win over the fall-through or register target
	assign next_pc = use_off ? pc_off : npc_base;

	// Result register
	logic [XLEN-1:0] next_pc_q;
	logic [2:0]      inst_size_q;
	logic            is_branch_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			next_pc_q   <= next_pc;
			inst_size_q <= len;
			is_branch_q <= is_br;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0000, is_branch_q, inst_size_q, 64'(next_pc_q)};

endmodule

`default_nettype wire
